### src/dns_pkg.sv
package dns_pkg;

    localparam int NumWidth   = 46;
    localparam int DenWidth   = 30;
    localparam int CountWidth = 6;
    localparam int MantWidth  = 30;

    localparam int MaxToken    = 10;
    localparam int PointNumber = 256;

    localparam logic [7:0] CharNul   = 8'h00;
    localparam logic [7:0] CharPoint = 8'h2E;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;

    typedef struct packed {
        logic                start;
        logic [NumWidth-1:0] numerator;
        logic [DenWidth-1:0] denominator;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    function automatic logic [DenWidth-1:0] pow10(input logic [3:0] exp_code);
        logic [DenWidth-1:0] result;
        case (exp_code)
            4'd0: result = 30'd1;
            4'd1: result = 30'd10;
            4'd2: result = 30'd100;
            4'd3: result = 30'd1000;
            4'd4: result = 30'd10000;
            4'd5: result = 30'd100000;
            4'd6: result = 30'd1000000;
            4'd7: result = 30'd10000000;
            4'd8: result = 30'd100000000;
            4'd9: result = 30'd1000000000;
            default: result = 30'd1;
        endcase
        return result;
    endfunction

endpackage

### src/dns_divider.sv
module dns_divider
    import dns_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_div_ctrl           i_ctrl,
    output t_div_status         o_status,
    output logic [NumWidth-1:0] o_quotient
);

    localparam logic [CountWidth-1:0] LastStep = CountWidth'(NumWidth - 1);

    logic [NumWidth-1:0]   r_quot, n_quot;
    logic [DenWidth-1:0]   r_rem, n_rem;
    logic [DenWidth-1:0]   r_den, n_den;
    logic [CountWidth-1:0] r_count, n_count;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;

    logic [DenWidth:0]     trial;
    logic [DenWidth:0]     diff;
    logic                  fits;

    assign trial = {r_rem, r_quot[NumWidth-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});

    always_comb begin
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_den   = r_den;
        n_count = r_count;
        n_busy  = r_busy;
        n_done  = r_done;
        if (i_ctrl.start) begin
            n_quot  = i_ctrl.numerator;
            n_rem   = '0;
            n_den   = i_ctrl.denominator;
            n_count = LastStep;
            n_busy  = 1'b1;
            n_done  = 1'b0;
        end else if (r_busy) begin
            n_quot = {r_quot[NumWidth-2:0], fits};
            n_rem  = fits ? diff[DenWidth-1:0] : trial[DenWidth-1:0];
            if (r_count == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_count = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quot;

`ifndef SYNTHESIS
    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("divider busy and done at once");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |-> !r_busy)
        else $error("divider started while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |=> r_busy && !r_done)
        else $error("divider did not start");

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_ctrl.start && r_count == '0) |=> r_done && !r_busy)
        else $error("divider did not finish after the last step");
`endif

endmodule

### src/decimal_number_scanner_unit.sv
// Decimal number scanner: takes one text byte per request and emits the value of each
// decimal number with a point in unsigned Q30.16, fraction truncated, with its slot number
// within the string. A byte that does not end a number never raises the stall. A byte that
// ends a number starts a restoring division by a power of ten on the single divider that
// produces one quotient bit per cycle while busy, so such a byte holds the input through
// the 46 division steps and until the quotient is loaded into the output register.
// The output register lets the next byte be taken while a result waits downstream.
module decimal_number_scanner_unit
    import dns_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_character,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [45:0] o_number_value,
    output logic [7:0]  o_slot,
    output logic        o_too_long
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    localparam logic [3:0] TokenMax = 4'(MaxToken);
    localparam logic [7:0] SlotLast = 8'(PointNumber - 1);

    logic                 r_state, n_state;
    logic                 r_frac, n_frac;
    logic [MantWidth-1:0] r_mant, n_mant;
    logic [3:0]           r_fdig, n_fdig;
    logic [3:0]           r_len, n_len;
    logic [7:0]           r_slot, n_slot;
    logic                 r_ovf, n_ovf;

    logic                 r_emit_too_long, n_emit_too_long;
    logic [7:0]           r_emit_slot, n_emit_slot;

    logic                 r_out_valid, n_out_valid;
    logic [NumWidth-1:0]  r_out_value, n_out_value;
    logic [7:0]           r_out_slot, n_out_slot;
    logic                 r_out_too_long, n_out_too_long;

    logic                 accept;
    logic                 is_digit;
    logic [3:0]           digit;
    logic                 room;
    logic [MantWidth-1:0] mant_next;
    logic [7:0]           slot_next;
    logic                 out_free;

    t_div_ctrl            div_ctrl;
    t_div_status          div_status;
    logic [NumWidth-1:0]  div_quotient;

    assign o_stall   = (r_state != ST_IDLE);
    assign accept    = i_valid && !o_stall;
    assign is_digit  = (i_character >= CharZero) && (i_character <= CharNine);
    assign digit     = 4'(i_character - CharZero);
    assign room      = (r_len < TokenMax);
    assign mant_next = {r_mant[MantWidth-4:0], 3'b000} + {r_mant[MantWidth-2:0], 1'b0}
                     + {{(MantWidth-4){1'b0}}, digit};
    assign slot_next = (r_slot == SlotLast) ? 8'd0 : r_slot + 8'd1;
    assign out_free  = !r_out_valid || !i_stall;

    always_comb begin
        n_state         = r_state;
        n_frac          = r_frac;
        n_mant          = r_mant;
        n_fdig          = r_fdig;
        n_len           = r_len;
        n_slot          = r_slot;
        n_ovf           = r_ovf;
        n_emit_slot     = r_emit_slot;
        n_emit_too_long = r_emit_too_long;
        div_ctrl.start       = 1'b0;
        div_ctrl.numerator   = {r_mant, 16'd0};
        div_ctrl.denominator = pow10(r_fdig);

        if (accept) begin
            if (r_frac) begin
                if (is_digit) begin
                    if (room) begin
                        n_mant = mant_next;
                        n_len  = r_len + 4'd1;
                        n_fdig = r_fdig + 4'd1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else begin
                    div_ctrl.start  = 1'b1;
                    n_emit_slot     = r_slot;
                    n_emit_too_long = r_ovf;
                    n_state         = ST_DIV;
                    n_frac          = 1'b0;
                    n_mant          = '0;
                    n_fdig          = '0;
                    n_len           = '0;
                    n_ovf           = 1'b0;
                    n_slot          = (i_character == CharNul) ? 8'd0 : slot_next;
                end
            end else begin
                if (is_digit) begin
                    if (room) begin
                        n_mant = mant_next;
                        n_len  = r_len + 4'd1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else if (i_character == CharPoint) begin
                    if (room) begin
                        n_len = r_len + 4'd1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_frac = 1'b1;
                    n_fdig = '0;
                end else begin
                    n_frac = 1'b0;
                    n_mant = '0;
                    n_fdig = '0;
                    n_len  = '0;
                    n_ovf  = 1'b0;
                    if (i_character == CharNul) begin
                        n_slot = 8'd0;
                    end
                end
            end
        end else if (r_state == ST_DIV && div_status.done && out_free) begin
            n_state = ST_IDLE;
        end
    end

    always_comb begin
        n_out_valid    = r_out_valid && i_stall;
        n_out_value    = r_out_value;
        n_out_slot     = r_out_slot;
        n_out_too_long = r_out_too_long;
        if (r_state == ST_DIV && div_status.done && out_free) begin
            n_out_valid    = 1'b1;
            n_out_value    = div_quotient;
            n_out_slot     = r_emit_slot;
            n_out_too_long = r_emit_too_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_frac      <= 1'b0;
            r_mant      <= '0;
            r_fdig      <= '0;
            r_len       <= '0;
            r_slot      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_frac      <= n_frac;
            r_mant      <= n_mant;
            r_fdig      <= n_fdig;
            r_len       <= n_len;
            r_slot      <= n_slot;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_emit_slot     <= n_emit_slot;
        r_emit_too_long <= n_emit_too_long;
        r_out_value     <= n_out_value;
        r_out_slot      <= n_out_slot;
        r_out_too_long  <= n_out_too_long;
    end

    dns_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (div_ctrl),
        .o_status   (div_status),
        .o_quotient (div_quotient)
    );

    assign o_valid        = r_out_valid;
    assign o_number_value = r_out_value;
    assign o_slot         = r_out_slot;
    assign o_too_long     = r_out_too_long;

endmodule

### test/decimal_number_scanner_unit_test.sv
`timescale 1ns / 1ps

module decimal_number_scanner_unit_test
    import dns_pkg::*;
();

    typedef enum logic [1:0] {
        ScanInt  = 2'd0,
        ScanFrac = 2'd1
    } t_scan_mode;

    typedef struct packed {
        logic [45:0] value;
        logic [7:0]  slot;
        logic        too_long;
    } t_number;

    typedef struct {
        logic [7:0] ch;
        bit         typed;
        t_number    want;
    } t_stimulus_row;

    localparam int OpeningRows  = 25;
    localparam int RandomItems  = 1100;
    localparam int WrapNumbers  = 260;
    localparam int SettleCycles = 100;
    localparam int PrintLimit   = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_character;
    logic        o_valid;
    logic        i_stall;
    logic [45:0] o_number_value;
    logic [7:0]  o_slot;
    logic        o_too_long;

    decimal_number_scanner_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_character    (i_character),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_number_value (o_number_value),
        .o_slot         (o_slot),
        .o_too_long     (o_too_long)
    );

    // The typed rows are a decimal point token (1.5), a lone point ended by a sign,
    // and a lone point right after an end of string, which restarts the slot count.
    t_stimulus_row opening_rows [OpeningRows] = '{
        '{"1", 1'b0, '0},
        '{CharPoint, 1'b0, '0},
        '{"5", 1'b0, '0},
        '{"x", 1'b1, t_number'{46'h18000, 8'd0, 1'b0}},
        '{CharPoint, 1'b0, '0},
        '{"-", 1'b1, t_number'{46'd0, 8'd1, 1'b0}},
        '{"-", 1'b0, '0},
        '{"7", 1'b0, '0},
        '{"+", 1'b0, '0},
        '{"1", 1'b0, '0},
        '{"2", 1'b0, '0},
        '{"3", 1'b0, '0},
        '{"4", 1'b0, '0},
        '{"5", 1'b0, '0},
        '{"6", 1'b0, '0},
        '{"7", 1'b0, '0},
        '{"8", 1'b0, '0},
        '{"9", 1'b0, '0},
        '{"0", 1'b0, '0},
        '{CharPoint, 1'b0, '0},
        '{"9", 1'b0, '0},
        '{CharNul, 1'b0, '0},
        '{CharPoint, 1'b0, '0},
        '{8'hFF, 1'b1, t_number'{46'd0, 8'd0, 1'b0}},
        '{CharNul, 1'b0, '0}
    };

    t_scan_mode  scan_mode;
    logic [29:0] mantissa;
    logic [3:0]  fraction_count;
    logic [3:0]  token_count;
    logic [7:0]  slot_count;
    logic        dropped;

    t_number expected_numbers [$];
    int      error_count;
    int      checked_numbers;
    int      characters_sent;
    int      slot_wraps;
    bit      sender_quiet;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < PrintLimit) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
        error_count++;
    endtask

    task automatic clear_run();
        scan_mode = ScanInt;
        mantissa = '0;
        fraction_count = '0;
        token_count = '0;
        dropped = 1'b0;
    endtask

    task automatic store_digit(input logic [7:0] digit, input bit in_fraction);
        logic [63:0] wide;
        if (token_count < MaxToken) begin
            wide = 64'(mantissa) * 64'd10 + 64'(digit);
            mantissa = wide[29:0];
            token_count = token_count + 4'd1;
            if (in_fraction) begin
                fraction_count = fraction_count + 4'd1;
            end
        end else begin
            dropped = 1'b1;
        end
    endtask

    task automatic predict_character(input logic [7:0] c, output bit emit, output t_number res);
        logic        is_digit;
        logic [45:0] scaled;
        logic [45:0] divisor;
        is_digit = (c >= CharZero) && (c <= CharNine);
        emit = 1'b0;
        res = '0;
        if (scan_mode == ScanFrac) begin
            if (is_digit) begin
                store_digit(c - CharZero, 1'b1);
            end else begin
                scaled = {mantissa, 16'h0000};
                divisor = 46'd1;
                repeat (fraction_count) divisor = divisor * 46'd10;
                res.value = scaled / divisor;
                res.slot = slot_count;
                res.too_long = dropped;
                emit = 1'b1;
                if (int'(slot_count) == PointNumber - 1) begin
                    slot_wraps++;
                end
                slot_count = 8'((int'(slot_count) + 1) % PointNumber);
                clear_run();
                if (c == CharNul) begin
                    slot_count = '0;
                end
            end
        end else if (is_digit) begin
            store_digit(c - CharZero, 1'b0);
        end else if (c == CharPoint) begin
            if (token_count < MaxToken) begin
                token_count = token_count + 4'd1;
            end else begin
                dropped = 1'b1;
            end
            scan_mode = ScanFrac;
            fraction_count = '0;
        end else begin
            clear_run();
            if (c == CharNul) begin
                slot_count = '0;
            end
        end
    endtask

    task automatic send_character(input logic [7:0] c, input bit typed = 1'b0,
                                  input t_number want = '0);
        int      gap;
        bit      emit;
        t_number res;
        gap = sender_quiet ? 0 : idle_length();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_character <= c;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        characters_sent++;
        predict_character(c, emit, res);
        if (emit) begin
            expected_numbers.push_back(typed ? want : res);
        end
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (expected_numbers.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    function automatic int digit_run_length();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return $urandom_range(0, 4);
        end else if (r < 9) begin
            return $urandom_range(5, 9);
        end
        return $urandom_range(10, 12);
    endfunction

    function automatic logic [7:0] pick_digit(input bit nines);
        return nines ? CharNine : CharZero + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_terminator(input bit allow_nul);
        int unsigned r;
        logic [7:0]  c;
        r = $urandom_range(0, 11);
        if (allow_nul && r == 0) begin
            return CharNul;
        end else if (r == 1) begin
            return CharPoint;
        end
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CharNul || (c >= CharZero && c <= CharNine));
        return c;
    endfunction

    task automatic send_number(input bit compact);
        int run;
        bit nines;
        nines = ($urandom_range(0, 9) == 0);
        run = compact ? $urandom_range(0, 1) : digit_run_length();
        repeat (run) send_character(pick_digit(nines));
        send_character(CharPoint);
        run = compact ? $urandom_range(0, 1) : digit_run_length();
        repeat (run) send_character(pick_digit(nines));
        send_character(pick_terminator(!compact));
    endtask

    task automatic send_noise();
        int run;
        run = $urandom_range(1, 4);
        if ($urandom_range(0, 1) == 0) begin
            repeat (run) send_character(8'($urandom_range(0, 255)));
        end else begin
            repeat (run) send_character(pick_digit(1'b0));
            send_character($urandom_range(0, 1) ? "-" : "+");
        end
    endtask

    initial begin
        i_stall <= 1'b0;
        forever begin
            int run;
            int hold;
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
            repeat (run) @(posedge i_clk);
            hold = idle_length();
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_number want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_numbers.size() == 0) begin
                report_mismatch($sformatf("unexpected number %0d in slot %0d",
                                          o_number_value, o_slot));
            end else begin
                want = expected_numbers.pop_front();
                checked_numbers++;
                if (o_number_value !== want.value) begin
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              o_number_value, want.value));
                end
                if (o_slot !== want.slot) begin
                    report_mismatch($sformatf("slot %0d, expected %0d", o_slot, want.slot));
                end
                if (o_too_long !== want.too_long) begin
                    report_mismatch($sformatf("too_long %0b, expected %0b",
                                              o_too_long, want.too_long));
                end
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_character <= CharNul;
        sender_quiet = 1'b0;
        error_count = 0;
        checked_numbers = 0;
        characters_sent = 0;
        slot_wraps = 0;
        clear_run();
        slot_count = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_rows[k]) begin
            send_character(opening_rows[k].ch, opening_rows[k].typed, opening_rows[k].want);
        end
        wait_for_drain();

        // One long string of short numbers drives the slot count through its wrap.
        send_character(CharNul);
        for (int k = 0; k < WrapNumbers; k++) begin
            sender_quiet = ($urandom_range(0, 7) == 0);
            send_number(1'b1);
        end

        while (characters_sent < OpeningRows + RandomItems) begin
            sender_quiet = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 4) == 0) begin
                send_noise();
            end
            send_number(1'b0);
            if ($urandom_range(0, 29) == 0) begin
                wait_for_drain();
            end
        end
        i_valid <= 1'b0;

        while (expected_numbers.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);

        $display("Scanned %0d characters and checked %0d numbers;",
                 characters_sent, checked_numbers);
        $display("the slot count wrapped %0d times.", slot_wraps);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
src/dns_pkg.sv
src/dns_divider.sv
src/decimal_number_scanner_unit.sv
test/decimal_number_scanner_unit_test.sv
